### sv/abd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types and constants of the armed button debouncer: event codes,
// configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } abd_event_e;

  localparam logic [CfgIdxW-1:0] CFG_STARTUP_GUARD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TO_ARM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE       = 2'd2;

  localparam logic [CfgW-1:0] STARTUP_GUARD_RST  = 16'd1000;
  localparam logic [CfgW-1:0] RELEASE_TO_ARM_RST = 16'd100;
  localparam logic [CfgW-1:0] DEBOUNCE_RST       = 16'd20;

endpackage : abd_pkg
`default_nettype wire

### sv/armed_button_debouncer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// armed_button_debouncer_top
// Button debouncer with a startup guard and a release-to-arm wait.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one beat per sample: a
//   free-running millisecond timestamp and the raw button level.
// - Output channel (out_valid_o / out_stall_i) returns exactly one beat per
//   input beat: none, press or release, in input order.
// - Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i):
//   index 0 startup guard, 1 release-to-arm time, 2 debounce time, all in ms.
//   Index 3 is ignored. Write only while the block is idle.
// - Path: a beat accepted into the input register is decided there and
//   moves on into the result register (two registers deep).
// - Throughput: one beat per cycle while the output is not stalled; the
//   decision is a pair of 32-bit subtract-and-compares and a few muxes
//   between the input register and the result register.
// - Stall: a held output stalls the input register, which in turn stalls
//   the input channel; nothing is dropped and the held beat stays stable.
// - Reset: both channels empty, debouncer unarmed, levels released,
//   registers at 1000 / 100 / 20 ms.
// ----------------------------------------------------------------------------
module armed_button_debouncer_top
  import abd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TimeW-1:0]   now_ms_i,
  input  wire logic               raw_pressed_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              button_event_o,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [CfgW-1:0] guard_q, arm_q, deb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= STARTUP_GUARD_RST;
      arm_q   <= RELEASE_TO_ARM_RST;
      deb_q   <= DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STARTUP_GUARD:  guard_q <= cfg_data_i;
        CFG_RELEASE_TO_ARM: arm_q   <= cfg_data_i;
        CFG_DEBOUNCE:       deb_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves when the result register is free
  // or being drained this cycle.
  logic             s1_valid_q;
  logic [TimeW-1:0] s1_now_q;
  logic             s1_level_q;
  logic             out_valid_q;
  abd_event_e       out_event_q;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload: load on accept only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q   <= now_ms_i;
      s1_level_q <= raw_pressed_i;
    end
  end

  // Debouncer state.
  logic             armed_q, armed_d;
  logic             wait_act_q, wait_act_d;
  logic [TimeW-1:0] wait_start_q, wait_start_d;
  logic             accepted_q, accepted_d;
  logic             pending_q, pending_d;
  logic [TimeW-1:0] pend_since_q, pend_since_d;
  abd_event_e       event_d;

  // Elapsed times wrap modulo 2^32; spans are zero-extended.
  logic [TimeW-1:0] arm_elapsed, deb_elapsed;
  logic             arm_done, deb_done, guarded;

  assign arm_elapsed = s1_now_q - wait_start_q;
  assign deb_elapsed = s1_now_q - pend_since_q;
  assign arm_done    = arm_elapsed >= {{(TimeW-CfgW){1'b0}}, arm_q};
  assign deb_done    = deb_elapsed >= {{(TimeW-CfgW){1'b0}}, deb_q};
  assign guarded     = s1_now_q < {{(TimeW-CfgW){1'b0}}, guard_q};

  always_comb begin
    armed_d      = armed_q;
    wait_act_d   = wait_act_q;
    wait_start_d = wait_start_q;
    accepted_d   = accepted_q;
    pending_d    = pending_q;
    pend_since_d = pend_since_q;
    event_d      = EV_NONE;
    priority if (guarded) begin
      // drop: too early after startup
    end else if (!armed_q) begin
      priority if (s1_level_q) begin
        wait_act_d = 1'b0;                 // press restarts the arm wait
      end else if (!wait_act_q) begin
        wait_act_d   = 1'b1;
        wait_start_d = s1_now_q;
      end else if (arm_done) begin
        armed_d      = 1'b1;
        accepted_d   = 1'b0;
        pending_d    = 1'b0;
        pend_since_d = s1_now_q;
      end else begin
        // hold: arm wait still running
      end
    end else if (s1_level_q != pending_q) begin
      pending_d    = s1_level_q;           // level moved: restart debounce
      pend_since_d = s1_now_q;
    end else if (pending_q != accepted_q && deb_done) begin
      accepted_d = pending_q;
      event_d    = pending_q ? EV_PRESS : EV_RELEASE;
    end else begin
      // hold: level steady or not settled yet
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      wait_act_q   <= 1'b0;
      wait_start_q <= '0;
      accepted_q   <= 1'b0;
      pending_q    <= 1'b0;
      pend_since_q <= '0;
    end else if (s1_fire) begin
      armed_q      <= armed_d;
      wait_act_q   <= wait_act_d;
      wait_start_q <= wait_start_d;
      accepted_q   <= accepted_d;
      pending_q    <= pending_d;
      pend_since_q <= pend_since_d;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_event_q <= event_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_event_o = out_event_q;

  // Assertions.
  a_unarmed_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> (!accepted_q && !pending_q))
    else $error("levels moved while unarmed");

  a_event_needs_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && event_d != EV_NONE) |-> armed_q)
    else $error("event emitted while unarmed");

  a_press_sets_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && event_d == EV_PRESS) |=> (accepted_q && out_valid_q))
    else $error("press event without accepted level");

  a_guard_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && guarded) |=> ($stable(armed_q) && $stable(accepted_q)
                              && $stable(pending_q) && $stable(wait_act_q)))
    else $error("guarded beat changed state");

endmodule : armed_button_debouncer_top
`default_nettype wire
